// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent holds -> consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/dpdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpdc_pkg
// Shared constants for the dual point-to-disc clamp.
// ----------------------------------------------------------------------------
package dpdc_pkg;
  localparam int OUT_W     = 17;
  localparam int CEN_W     = 11;
  localparam int RAD_W     = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 3'd4;

  localparam logic [CEN_W-1:0] RST_LEFT_X  = 11'd350;
  localparam logic [CEN_W-1:0] RST_LEFT_Y  = 11'd300;
  localparam logic [CEN_W-1:0] RST_RIGHT_X = 11'd450;
  localparam logic [CEN_W-1:0] RST_RIGHT_Y = 11'd300;
  localparam logic [RAD_W-1:0] RST_RADIUS  = 8'd30;
endpackage

// File: hw/rtl/dpdc_root_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpdc_root_step
// One bit of the scaled-root search: try setting bit B of q and keep it when
// (2q-1)^2 * s stays within the bound and q stays within the radius limit.
// q^2*s and q*s are updated by shifts and adds only.
// ----------------------------------------------------------------------------
module dpdc_root_step #(
  parameter int QB = 12,
  parameter int SW = 25,
  parameter int PW = 51,
  parameter int B  = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [QB-1:0] hi_i,
  input  logic [SW-1:0] s_i,
  input  logic [PW-1:0] bnd_i,
  input  logic [QB-1:0] q_i,
  input  logic [PW-1:0] p_i,
  input  logic [PW-1:0] l_i,
  output logic [QB-1:0] q_o,
  output logic [PW-1:0] p_o,
  output logic [PW-1:0] l_o
);
  logic [QB-1:0] cand;
  logic [PW-1:0] s_w, p_c, l_c, t_c;
  logic          keep;
  logic [QB-1:0] q_q;
  logic [PW-1:0] p_q, l_q;

  always_comb begin
    s_w  = PW'(s_i);
    cand = q_i | (QB'(1) << B);
    p_c  = p_i + (l_i << (B + 1)) + (s_w << (2 * B));
    l_c  = l_i + (s_w << B);
    t_c  = (p_c << 2) - (l_c << 2) + s_w;
    keep = (cand <= hi_i) && (t_c <= bnd_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= keep ? cand : q_i;
      p_q <= keep ? p_c : p_i;
      l_q <= keep ? l_c : l_i;
    end
  end

  assign q_o = q_q;
  assign p_o = p_q;
  assign l_o = l_q;
endmodule

// File: hw/rtl/dpdc_disc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpdc_disc
// Clamp pipeline for one centre: offset, squares, bound, bitwise root search
// for both axes, then select and saturate.
// ----------------------------------------------------------------------------
module dpdc_disc #(
  parameter int CB = 12,
  parameter int FB = 4
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [CB-1:0]             px_i,
  input  logic signed [CB-1:0]             py_i,
  input  logic [dpdc_pkg::CEN_W-1:0]       cx_i,
  input  logic [dpdc_pkg::CEN_W-1:0]       cy_i,
  input  logic [dpdc_pkg::RAD_W-1:0]       r_i,
  output logic signed [dpdc_pkg::OUT_W-1:0] ox_o,
  output logic signed [dpdc_pkg::OUT_W-1:0] oy_o
);
  import dpdc_pkg::*;

  localparam int DW  = ((CB > 12) ? CB : 12) + 1;
  localparam int AW  = DW - 1;
  localparam int SW  = 2 * AW + 1;
  localparam int RAW = AW + RAD_W;
  localparam int QB  = RAD_W + FB;
  localparam int PW  = 2 * AW + 2 * FB + 19;
  // wide enough for the result and for both output limits
  localparam int VW  = ((DW + FB + 2) > OUT_W) ? (DW + FB + 2) : (OUT_W + 1);

  // stage 1: offsets
  logic signed [DW-1:0] dx_q, dy_q;
  logic signed [CB-1:0] px1_q, py1_q;
  // stage 2: magnitudes and products
  logic [2*AW-1:0]      ax2_q, ay2_q;
  logic [RAW-1:0]       rax_q, ray_q;
  logic                 sx2_q, sy2_q;
  logic signed [CB-1:0] px2_q, py2_q;
  logic [DW-1:0]        ndx, ndy;
  logic [AW-1:0]        ax, ay;
  // stage 3 onward: carried along the search
  logic [SW-1:0]        s_p   [QB+1];
  logic [PW-1:0]        bx_p  [QB+1];
  logic [PW-1:0]        by_p  [QB+1];
  logic                 in_p  [QB+1];
  logic                 sx_p  [QB+1];
  logic                 sy_p  [QB+1];
  logic signed [CB-1:0] px_p  [QB+1];
  logic signed [CB-1:0] py_p  [QB+1];
  logic [QB-1:0]        qx_p  [QB+1];
  logic [QB-1:0]        qy_p  [QB+1];
  logic [PW-1:0]        px2p  [QB+1];
  logic [PW-1:0]        lx_p  [QB+1];
  logic [PW-1:0]        py2p  [QB+1];
  logic [PW-1:0]        ly_p  [QB+1];

  logic [SW-1:0]        s_d;
  logic [2*RAW-1:0]     rxsq, rysq;
  logic [QB-1:0]        hi;

  assign hi = QB'(r_i) << FB;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q  <= $signed({{(DW-CB){px_i[CB-1]}}, px_i}) -
               $signed({{(DW-CEN_W){1'b0}}, cx_i});
      dy_q  <= $signed({{(DW-CB){py_i[CB-1]}}, py_i}) -
               $signed({{(DW-CEN_W){1'b0}}, cy_i});
      px1_q <= px_i;
      py1_q <= py_i;
    end
  end

  always_comb begin
    ndx = -dx_q;
    ndy = -dy_q;
    ax  = dx_q[DW-1] ? ndx[AW-1:0] : dx_q[AW-1:0];
    ay  = dy_q[DW-1] ? ndy[AW-1:0] : dy_q[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax2_q <= ax * ax;
      ay2_q <= ay * ay;
      rax_q <= RAW'(r_i) * RAW'(ax);
      ray_q <= RAW'(r_i) * RAW'(ay);
      sx2_q <= dx_q[DW-1];
      sy2_q <= dy_q[DW-1];
      px2_q <= px1_q;
      py2_q <= py1_q;
    end
  end

  always_comb begin
    s_d  = SW'(ax2_q) + SW'(ay2_q);
    rxsq = rax_q * rax_q;
    rysq = ray_q * ray_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_p[0]  <= s_d;
      in_p[0] <= s_d <= SW'(r_i * r_i);
      bx_p[0] <= PW'(rxsq) << (2 * FB + 2);
      by_p[0] <= PW'(rysq) << (2 * FB + 2);
      sx_p[0] <= sx2_q;
      sy_p[0] <= sy2_q;
      px_p[0] <= px2_q;
      py_p[0] <= py2_q;
    end
  end

  assign qx_p[0] = '0;
  assign qy_p[0] = '0;
  assign px2p[0] = '0;
  assign lx_p[0] = '0;
  assign py2p[0] = '0;
  assign ly_p[0] = '0;

  for (genvar k = 0; k < QB; k++) begin : g_step
    dpdc_root_step #(.QB(QB), .SW(SW), .PW(PW), .B(QB - 1 - k)) u_x (
      .clk_i (clk_i), .en_i (en_i), .hi_i (hi), .s_i (s_p[k]), .bnd_i (bx_p[k]),
      .q_i (qx_p[k]), .p_i (px2p[k]), .l_i (lx_p[k]),
      .q_o (qx_p[k+1]), .p_o (px2p[k+1]), .l_o (lx_p[k+1])
    );
    dpdc_root_step #(.QB(QB), .SW(SW), .PW(PW), .B(QB - 1 - k)) u_y (
      .clk_i (clk_i), .en_i (en_i), .hi_i (hi), .s_i (s_p[k]), .bnd_i (by_p[k]),
      .q_i (qy_p[k]), .p_i (py2p[k]), .l_i (ly_p[k]),
      .q_o (qy_p[k+1]), .p_o (py2p[k+1]), .l_o (ly_p[k+1])
    );
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_p[k+1]  <= s_p[k];
        bx_p[k+1] <= bx_p[k];
        by_p[k+1] <= by_p[k];
        in_p[k+1] <= in_p[k];
        sx_p[k+1] <= sx_p[k];
        sy_p[k+1] <= sy_p[k];
        px_p[k+1] <= px_p[k];
        py_p[k+1] <= py_p[k];
      end
    end
  end

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] hi_lim, lo_lim;
    hi_lim = VW'(signed'((1 << (OUT_W - 1)) - 1));
    lo_lim = -VW'(signed'(1 << (OUT_W - 1)));
    if (v > hi_lim) begin
      sat_out = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (v < lo_lim) begin
      sat_out = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat_out = v[OUT_W-1:0];
    end
  endfunction

  logic signed [VW-1:0] inx, iny, bsx, bsy, fx, fy, vx, vy;

  always_comb begin
    inx = $signed({{(VW-CB){px_p[QB][CB-1]}}, px_p[QB]}) <<< FB;
    iny = $signed({{(VW-CB){py_p[QB][CB-1]}}, py_p[QB]}) <<< FB;
    bsx = $signed({{(VW-CEN_W){1'b0}}, cx_i}) <<< FB;
    bsy = $signed({{(VW-CEN_W){1'b0}}, cy_i}) <<< FB;
    fx  = $signed({{(VW-QB){1'b0}}, qx_p[QB]});
    fy  = $signed({{(VW-QB){1'b0}}, qy_p[QB]});
    vx  = in_p[QB] ? inx : (sx_p[QB] ? bsx - fx : bsx + fx);
    vy  = in_p[QB] ? iny : (sy_p[QB] ? bsy - fy : bsy + fy);
    ox_o = sat_out(vx);
    oy_o = sat_out(vy);
  end
endmodule

// File: hw/rtl/dual_point_disc_clamp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_point_disc_clamp
// Clamp one pointer position onto two discs of common radius about two
// configured centres; results in signed fixed point, rounded to nearest.
// ----------------------------------------------------------------------------
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+-------------------------------------------
//  in      | valid_i | stall_o | mouse_x_i, mouse_y_i
//  out     | valid_o | stall_i | left_x_o, left_y_o, right_x_o, right_y_o
//  config  | cfg_we_i (no backpressure) | cfg_idx_i, cfg_wdata_i
//
// One request enters per cycle while no finished result is stalled. The pipeline
// has offset, squares and bound stages, one per root bit, one output register.
// Reset clears the valid chain and loads the default centres and radius.
// A stalled result holds the whole pipeline in place; bubbles keep moving
// only when the output stage is free.
module dual_point_disc_clamp #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dpdc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dpdc_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  logic signed [COORD_BITS-1:0]        mouse_x_i,
  input  logic signed [COORD_BITS-1:0]        mouse_y_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output logic signed [dpdc_pkg::OUT_W-1:0]   left_x_o,
  output logic signed [dpdc_pkg::OUT_W-1:0]   left_y_o,
  output logic signed [dpdc_pkg::OUT_W-1:0]   right_x_o,
  output logic signed [dpdc_pkg::OUT_W-1:0]   right_y_o
);
  import dpdc_pkg::*;

  // offset, magnitude, sum stages + one per root bit + output register
  localparam int DEPTH = 3 + RAD_W + FRAC_BITS + 1;

  logic [CEN_W-1:0] lcx_q, lcy_q, rcx_q, rcy_q;
  logic [RAD_W-1:0] rad_q;
  logic [DEPTH-1:0] vld_q;
  logic             en;

  logic signed [OUT_W-1:0] lx, ly, rx, ry;
  logic signed [OUT_W-1:0] lx_q, ly_q, rx_q, ry_q;

  // Configuration: indexes beyond the radius are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcx_q <= RST_LEFT_X;
      lcy_q <= RST_LEFT_Y;
      rcx_q <= RST_RIGHT_X;
      rcy_q <= RST_RIGHT_Y;
      rad_q <= RST_RADIUS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LEFT_X:  lcx_q <= cfg_wdata_i;
        CFG_LEFT_Y:  lcy_q <= cfg_wdata_i;
        CFG_RIGHT_X: rcx_q <= cfg_wdata_i;
        CFG_RIGHT_Y: rcy_q <= cfg_wdata_i;
        CFG_RADIUS:  rad_q <= cfg_wdata_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance everything unless a finished result waits on a stalled sink.
  assign en      = !(vld_q[DEPTH-1] && stall_i);
  assign stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], valid_i};
    end
  end

  dpdc_disc #(.CB(COORD_BITS), .FB(FRAC_BITS)) u_left (
    .clk_i (clk_i), .en_i (en), .px_i (mouse_x_i), .py_i (mouse_y_i),
    .cx_i (lcx_q), .cy_i (lcy_q), .r_i (rad_q), .ox_o (lx), .oy_o (ly)
  );

  dpdc_disc #(.CB(COORD_BITS), .FB(FRAC_BITS)) u_right (
    .clk_i (clk_i), .en_i (en), .px_i (mouse_x_i), .py_i (mouse_y_i),
    .cx_i (rcx_q), .cy_i (rcy_q), .r_i (rad_q), .ox_o (rx), .oy_o (ry)
  );

  // Output register: hold while stalled.
  always_ff @(posedge clk_i) begin
    if (en) begin
      lx_q <= lx;
      ly_q <= ly;
      rx_q <= rx;
      ry_q <= ry;
    end
  end

  assign valid_o   = vld_q[DEPTH-1];
  assign left_x_o  = lx_q;
  assign left_y_o  = ly_q;
  assign right_x_o = rx_q;
  assign right_y_o = ry_q;
endmodule

// File: hw/rtl/dpdc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpdc_checker
// Port-level checks of the clamp's backpressure and output hold.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpdc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              stall_o,
  input logic                              valid_o,
  input logic                              stall_i,
  input logic signed [dpdc_pkg::OUT_W-1:0] left_x_o,
  input logic signed [dpdc_pkg::OUT_W-1:0] right_y_o
);
  // Input stalls only behind a blocked result.
  `ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, stall_o, valid_o && stall_i)
  // A blocked result always pushes back on the input.
  `ASSERT_IMPL(a_stall_back, clk_i, rst_ni, valid_o && stall_i, stall_o)
  // A blocked result holds.
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, valid_o && stall_i,
               valid_o && $stable(left_x_o) && $stable(right_y_o))
endmodule

bind dual_point_disc_clamp dpdc_checker u_dpdc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .stall_o   (stall_o),
  .valid_o   (valid_o),
  .stall_i   (stall_i),
  .left_x_o  (left_x_o),
  .right_y_o (right_y_o)
);
